/* src/wireworld_row_generation_step_unit_defines.svh */
// ----------------------------------------------------------------------------
// Wireworld row generation step unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef WIREWORLD_ROW_GENERATION_STEP_UNIT_DEFINES_SVH
`define WIREWORLD_ROW_GENERATION_STEP_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WWRGS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define WWRGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wwrgs_pkg.sv */
// ----------------------------------------------------------------------------
// Wireworld row generation step package
// Cell codes, row geometry and result types shared by the unit.
// ----------------------------------------------------------------------------
package wwrgs_pkg;

    localparam int CELL_W     = 2;
    localparam int ROW_CELLS  = 16;
    localparam int ROW_W      = CELL_W * ROW_CELLS;
    localparam int CFG_W      = 5;
    localparam int NBR_CNT    = 8;
    localparam int GRID_WIDTH_DEF = 16;

    localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST = CFG_W'(16);

    typedef enum logic [CELL_W-1:0] {
        CELL_EMPTY = 2'd0,
        CELL_HEAD  = 2'd1,
        CELL_TAIL  = 2'd2,
        CELL_WIRE  = 2'd3
    } t_cell;

    typedef logic [ROW_W-1:0] t_row;

    // One result row as it waits in the output queue.
    typedef struct packed {
        t_row cells;
        logic done;
    } t_result;

endpackage

/* src/wwrgs_ifs.sv */
// ----------------------------------------------------------------------------
// Wireworld row generation step channels
// Valid/ready channels for input rows and next-generation result rows.
// ----------------------------------------------------------------------------
interface wwrgs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_cells;
    logic        last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface wwrgs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_row_cells;
    logic        frame_done;

    modport source (output valid, output next_row_cells, output frame_done, input ready);
    modport sink   (input valid, input next_row_cells, input frame_done, output ready);
endinterface

/* src/wwrgs_lane.sv */
// ----------------------------------------------------------------------------
// Wireworld cell lane
// Next state of one cell from its own code and its neighbors' head flags.
// ----------------------------------------------------------------------------
module wwrgs_lane (
    input  wwrgs_pkg::t_cell                   i_cell,
    input  logic [wwrgs_pkg::NBR_CNT-1:0]      i_nbr_head,
    output wwrgs_pkg::t_cell                   o_cell
);
    import wwrgs_pkg::*;

    logic [3:0] head_cnt;
    logic       fire;

    always_comb begin
        head_cnt = '0;
        for (int i = 0; i < NBR_CNT; i++) begin
            head_cnt = head_cnt + 4'(i_nbr_head[i]);
        end
    end

    assign fire = (head_cnt == 4'd1) || (head_cnt == 4'd2);

    always_comb begin
        unique case (i_cell)
            CELL_HEAD: o_cell = CELL_TAIL;
            CELL_TAIL: o_cell = CELL_WIRE;
            CELL_WIRE: o_cell = fire ? CELL_HEAD : CELL_WIRE;
            default:   o_cell = CELL_EMPTY;
        endcase
    end

endmodule

/* src/wwrgs_row_gen.sv */
// ----------------------------------------------------------------------------
// Wireworld row generator
// Clips three rows to the active columns, runs one lane per cell and
// merges the lane outputs into the next-generation row.
// ----------------------------------------------------------------------------
module wwrgs_row_gen #(
    parameter int GRID_WIDTH = wwrgs_pkg::GRID_WIDTH_DEF
) (
    input  logic [wwrgs_pkg::CFG_W-1:0] i_active_width,
    input  wwrgs_pkg::t_row             i_up,
    input  wwrgs_pkg::t_row             i_mid,
    input  wwrgs_pkg::t_row             i_down,
    output wwrgs_pkg::t_row             o_next
);
    import wwrgs_pkg::*;

    localparam int GridCols = (GRID_WIDTH < ROW_CELLS) ? GRID_WIDTH : ROW_CELLS;

    logic [ROW_CELLS-1:0] col_en;
    t_row                 up_c, mid_c, down_c;
    // Head flags padded by one empty column on each side.
    logic [ROW_CELLS+1:0] hu, hm, hd;

    always_comb begin
        for (int k = 0; k < ROW_CELLS; k++) begin
            col_en[k] = (CFG_W'(k) < i_active_width) && (k < GridCols);
        end
    end

    always_comb begin
        hu = '0;
        hm = '0;
        hd = '0;
        for (int k = 0; k < ROW_CELLS; k++) begin
            up_c[CELL_W*k +: CELL_W]   = col_en[k] ? i_up[CELL_W*k +: CELL_W]   : CELL_EMPTY;
            mid_c[CELL_W*k +: CELL_W]  = col_en[k] ? i_mid[CELL_W*k +: CELL_W]  : CELL_EMPTY;
            down_c[CELL_W*k +: CELL_W] = col_en[k] ? i_down[CELL_W*k +: CELL_W] : CELL_EMPTY;
            hu[k+1] = (up_c[CELL_W*k +: CELL_W]   == CELL_HEAD);
            hm[k+1] = (mid_c[CELL_W*k +: CELL_W]  == CELL_HEAD);
            hd[k+1] = (down_c[CELL_W*k +: CELL_W] == CELL_HEAD);
        end
    end

    for (genvar k = 0; k < ROW_CELLS; k++) begin : g_lane
        t_cell lane_out;

        wwrgs_lane u_lane (
            .i_cell     (t_cell'(mid_c[CELL_W*k +: CELL_W])),
            .i_nbr_head ({hu[k+2:k], hm[k+2], hm[k], hd[k+2:k]}),
            .o_cell     (lane_out)
        );

        assign o_next[CELL_W*k +: CELL_W] = lane_out;
    end

endmodule

/* src/wireworld_row_generation_step_unit.sv */
// ----------------------------------------------------------------------------
// Wireworld row generation step unit
// Usage: rows of a grid enter top row first on i_row (valid/ready), 16
// two-bit cells per row, last_row marking the frame's final row. Each
// accepted row releases the next generation of the row before it on o_row;
// the final row also releases its own result, flagged with frame_done.
// active_width is written through i_cfg_wr_en/i_cfg_wr_data by the user only while idle; the block does not enforce it.
// Results: each result is registered in the output queue before it leaves
//   on o_row; the two results of a final row leave in order.
// Throughput: one row per cycle while at most one result is queued. A final row
//   arriving behind a pending row yields two results, and since o_row moves at
//   most one result per cycle, i_row drops ready while two or more are queued.
// Reset: clears the pending row, empties the output queue and sets
//   active_width to 16; the next row starts a new frame.
// Stall: a three-entry output queue takes results while o_row is stalled;
//   i_row accepts only while at most one result is queued.
// ----------------------------------------------------------------------------
`include "wireworld_row_generation_step_unit_defines.svh"

module wireworld_row_generation_step_unit #(
    parameter int GRID_WIDTH = wwrgs_pkg::GRID_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [wwrgs_pkg::CFG_W-1:0] i_cfg_wr_data,
    wwrgs_in_if.sink                    i_row,
    wwrgs_out_if.source                 o_row
);
    import wwrgs_pkg::*;

    localparam int QDepth = 3;

    logic [CFG_W-1:0] r_active_width;
    t_row             r_row_above, n_row_above;
    t_row             r_row_pend,  n_row_pend;
    logic             r_pend_vld,  n_pend_vld;
    t_result          r_q [QDepth];
    t_result          n_q [QDepth];
    logic [1:0]       r_cnt, n_cnt;

    logic             acc, pop;
    logic [1:0]       push;
    t_row             gen_pend, gen_last, above_new;
    t_result          res_a, res_b;

    assign acc = i_row.valid && i_row.ready;
    assign pop = o_row.valid && o_row.ready;

    assign i_row.ready          = (r_cnt < 2'd2);
    assign o_row.valid          = (r_cnt != 2'd0);
    assign o_row.next_row_cells = r_q[0].cells;
    assign o_row.frame_done     = r_q[0].done;

    assign above_new = r_pend_vld ? r_row_pend : '0;

    wwrgs_row_gen #(.GRID_WIDTH(GRID_WIDTH)) u_gen_pend (
        .i_active_width (r_active_width),
        .i_up           (r_row_above),
        .i_mid          (r_row_pend),
        .i_down         (i_row.row_cells),
        .o_next         (gen_pend)
    );

    wwrgs_row_gen #(.GRID_WIDTH(GRID_WIDTH)) u_gen_last (
        .i_active_width (r_active_width),
        .i_up           (above_new),
        .i_mid          (i_row.row_cells),
        .i_down         ('0),
        .o_next         (gen_last)
    );

    // Pending row's result goes first; the final row's own result follows.
    assign res_a = r_pend_vld ? '{cells: gen_pend, done: 1'b0}
                              : '{cells: gen_last, done: 1'b1};
    assign res_b = '{cells: gen_last, done: 1'b1};
    assign push  = acc ? (2'(r_pend_vld) + 2'(i_row.last_row)) : 2'd0;

    always_comb begin
        logic [1:0] base;
        base        = r_cnt - 2'(pop);
        n_cnt       = base + push;
        n_row_above = r_row_above;
        n_row_pend  = r_row_pend;
        n_pend_vld  = r_pend_vld;
        for (int i = 0; i < QDepth; i++) begin
            // Advance the queue on a transfer out, then append new results.
            n_q[i] = (pop && (i < QDepth - 1)) ? r_q[(i + 1) % QDepth] : r_q[i];
            if ((push != 2'd0) && (2'(i) == base)) begin
                n_q[i] = res_a;
            end else if ((push == 2'd2) && (2'(i) == base + 2'd1)) begin
                n_q[i] = res_b;
            end
        end
        if (acc) begin
            if (i_row.last_row) begin
                n_row_above = '0;
                n_row_pend  = '0;
                n_pend_vld  = 1'b0;
            end else begin
                n_row_above = above_new;
                n_row_pend  = i_row.row_cells;
                n_pend_vld  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width <= ACTIVE_WIDTH_RST;
            r_pend_vld     <= 1'b0;
            r_cnt          <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_active_width <= i_cfg_wr_data;
            end
            r_pend_vld <= n_pend_vld;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_above <= n_row_above;
        r_row_pend  <= n_row_pend;
        for (int i = 0; i < QDepth; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    `WWRGS_ASSERT_NEXT(a_last_clears_pend, acc && i_row.last_row, !r_pend_vld, "final row left a pending row")
    `WWRGS_ASSERT_NEXT(a_row_sets_pend, acc && !i_row.last_row, r_pend_vld, "non-final row not held as pending")
    `WWRGS_ASSERT_NEXT(a_pair_order, acc && i_row.last_row && r_pend_vld && (r_cnt == 2'd0), o_row.valid && !o_row.frame_done, "pending result not sent ahead of final row result")
    `WWRGS_ASSERT_NEXT(a_quiet_row, acc && !r_pend_vld && !i_row.last_row && !pop, r_cnt == $past(r_cnt), "first row of frame produced a result")

endmodule

/* tb/wireworld_row_generation_step_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wireworld row generation step unit testbench
// Streams frames of packed cell rows into the unit and checks every
// next-generation row against a cycle-free predictor kept in a scoreboard.
// It covers hand-picked edge patterns, then random frames under several
// column widths and a mix of sender and receiver stalls.
// ----------------------------------------------------------------------------
module wireworld_row_generation_step_unit_tb;
    import wwrgs_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 9;
    localparam int SEG_ROWS    = 180;
    localparam int NUM_SEGS    = 6;
    localparam int SETTLE      = 6;
    // about 1100 rows under the heaviest idling, plus two results for some rows
    // behind receiver stalls and drains; the limit sits far above what they need
    localparam int CYCLE_LIMIT = 400000;

    class generation_scoreboard;
        t_row             row_above;
        t_row             row_held;
        bit               held;
        logic [CFG_W-1:0] width;
        t_result          due_rows[$];
        int               errors;
        int               rows_noted;
        int               results_checked;
        int               frames_closed;

        function new();
            width           = ACTIVE_WIDTH_RST;
            errors          = 0;
            rows_noted      = 0;
            results_checked = 0;
            frames_closed   = 0;
            restart();
        endfunction

        function void restart();
            row_above = '0;
            row_held  = '0;
            held      = 1'b0;
        endfunction

        function bit is_head(t_row r, int col);
            return t_cell'(r[CELL_W*col +: CELL_W]) == CELL_HEAD;
        endfunction

        // Next generation of mid, given the rows above and below it.
        function t_row evolve(t_row up, t_row mid, t_row down);
            int    cols;
            int    heads;
            t_row  keep;
            t_row  nxt;
            t_cell c;
            cols = (width > ROW_CELLS) ? ROW_CELLS : int'(width);
            if (cols > GRID_WIDTH_DEF) cols = GRID_WIDTH_DEF;
            keep = (cols >= ROW_CELLS) ? '1 : t_row'((32'd1 << (CELL_W * cols)) - 1);
            up   = up & keep;
            mid  = mid & keep;
            down = down & keep;
            nxt  = '0;
            for (int k = 0; k < ROW_CELLS; k++) begin
                c = t_cell'(mid[CELL_W*k +: CELL_W]);
                case (c)
                    CELL_HEAD: nxt[CELL_W*k +: CELL_W] = CELL_TAIL;
                    CELL_TAIL: nxt[CELL_W*k +: CELL_W] = CELL_WIRE;
                    CELL_WIRE: begin
                        heads = 0;
                        for (int j = k - 1; j <= k + 1; j++) begin
                            if (j >= 0 && j < ROW_CELLS) begin
                                if (is_head(up, j)) heads++;
                                if (is_head(down, j)) heads++;
                                if (j != k && is_head(mid, j)) heads++;
                            end
                        end
                        nxt[CELL_W*k +: CELL_W] = (heads == 1 || heads == 2) ? CELL_HEAD
                                                                              : CELL_WIRE;
                    end
                    default: nxt[CELL_W*k +: CELL_W] = CELL_EMPTY;
                endcase
            end
            return nxt;
        endfunction

        function void note_row(t_row row, bit is_last);
            t_row    above_next;
            t_result r;
            above_next = '0;
            rows_noted++;
            if (held) begin
                r.cells = evolve(row_above, row_held, row);
                r.done  = 1'b0;
                due_rows.push_back(r);
                above_next = row_held;
            end
            if (is_last) begin
                r.cells = evolve(above_next, row, '0);
                r.done  = 1'b1;
                due_rows.push_back(r);
                frames_closed++;
                restart();
            end else begin
                row_above = above_next;
                row_held  = row;
                held      = 1'b1;
            end
        endfunction

        function void check_row(t_row cells, logic done);
            t_result want;
            if (due_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected result row cells=%h frame_done=%b",
                         $time, cells, done);
                return;
            end
            want = due_rows.pop_front();
            results_checked++;
            if (cells !== want.cells) begin
                errors++;
                $display("%0t: next_row_cells mismatch: expected %h, got %h",
                         $time, want.cells, cells);
            end
            if (done !== want.done) begin
                errors++;
                $display("%0t: frame_done mismatch: expected %b, got %b",
                         $time, want.done, done);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    wwrgs_in_if  row_in ();
    wwrgs_out_if row_out ();

    int tx_idle_pct = 34;
    int rx_idle_pct = 62;
    int cycle_count = 0;
    generation_scoreboard board;

    wireworld_row_generation_step_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_row         (row_in),
        .o_row         (row_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && row_out.valid === 1'b1 && row_out.ready === 1'b1)
            board.check_row(row_out.next_row_cells, row_out.frame_done);
        row_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task send_row(t_row cells, bit is_last);
        // Idle the sender cycle by cycle at the chosen rate.
        while ($urandom_range(99) < tx_idle_pct) begin
            row_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        row_in.valid     <= 1'b1;
        row_in.row_cells <= cells;
        row_in.last_row  <= is_last;
        do @(posedge i_clk); while (row_in.ready !== 1'b1);
        board.note_row(cells, is_last);
    endtask

    // Hold the sender until every due result has left the unit.
    task drain();
        row_in.valid <= 1'b0;
        while (board.due_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_width(logic [CFG_W-1:0] w);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.width = w;
    endtask

    // Mostly wire-heavy rows so the head-count rule fires often.
    function t_row rand_row();
        t_row r;
        int   pick;
        r = $urandom;
        if ($urandom_range(3) != 0) begin
            for (int k = 0; k < ROW_CELLS; k++) begin
                pick = $urandom_range(9);
                if (pick < 2)      r[CELL_W*k +: CELL_W] = CELL_EMPTY;
                else if (pick < 4) r[CELL_W*k +: CELL_W] = CELL_HEAD;
                else if (pick < 5) r[CELL_W*k +: CELL_W] = CELL_TAIL;
                else               r[CELL_W*k +: CELL_W] = CELL_WIRE;
            end
        end
        return r;
    endfunction

    // Random frames; the last one may be cut off and carried into the next setting.
    task run_segment(int rows);
        int   left;
        int   frame_len;
        t_row cells;
        left = rows;
        while (left > 0) begin
            frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int r = 0; r < frame_len && left > 0; r++) begin
                cells = rand_row();
                send_row(cells, r == frame_len - 1);
                left--;
            end
            if ($urandom_range(19) == 0) drain();
        end
    endtask

    initial begin
        logic [CFG_W-1:0] widths[NUM_SEGS];
        board = new();
        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_wr_data    <= '0;
        row_in.valid     <= 1'b0;
        row_in.row_cells <= '0;
        row_in.last_row  <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-row frame of plain wire
        send_row(32'hFFFF_FFFF, 1'b1);
        // heads over wire over tails: counts of two at the edges, three inside
        send_row(32'h5555_5555, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hAAAA_AAAA, 1'b1);
        // lone heads in the outer columns
        send_row(32'h4000_0001, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0000, 1'b1);
        send_row(32'h0000_0000, 1'b1);
        // head inside the wire row, then alternating heads below
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'hFFFF_FFF7, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h1111_1111, 1'b1);
        // heads above and below the wire row, two columns apart
        send_row(32'h0000_0001, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0010, 1'b1);

        widths[0] = 5'd1;
        widths[1] = 5'd31;
        widths[2] = 5'd0;
        widths[3] = CFG_W'($urandom_range(2, 15));
        widths[4] = 5'd16;
        widths[5] = CFG_W'($urandom_range(17, 30));
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            write_width(widths[seg]);
            case (seg / 2)
                0:       begin tx_idle_pct = 34; rx_idle_pct = 62; end
                1:       begin tx_idle_pct = 62; rx_idle_pct = 34; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            run_segment(SEG_ROWS);
        end
        drain();

        $display("Run covered %0d rows, %0d result rows checked, %0d frames closed",
                 board.rows_noted, board.results_checked, board.frames_closed);
        $display("Widths 16 %0d %0d %0d %0d %0d %0d under three stall mixes",
                 widths[0], widths[1], widths[2], widths[3], widths[4], widths[5]);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
